// File: src/cfgv_pkg.sv
// Shared types, constants and reset contents for the display adapter config space.
// Used by the bank, BAR and top-level modules; depends on nothing.
package cfgv_pkg;

  // Block configuration
  localparam logic [31:0] FbBase = 32'hE000_0000;
  localparam int unsigned VidMemMb = 16;

  // BAR0 mask: clear everything below the video memory size (taken in 32 bits)
  localparam logic [63:0] VidMemBytes = 64'(VidMemMb) << 20;
  localparam logic [31:0] BarMask = 32'(~(VidMemBytes - 64'd1));
  localparam logic [31:0] BarReset = FbBase | 32'h0000_0008;

  // Storage geometry: four byte lanes of 64 rows each
  localparam int unsigned NumLanes = 4;
  localparam int unsigned LaneW = 2;
  localparam int unsigned RowCnt = 64;
  localparam int unsigned RowW = 6;

  // Special offsets
  localparam logic [7:0] AddrCmdLo = 8'h04;
  localparam logic [7:0] AddrStsLo = 8'h06;
  localparam logic [5:0] RowBar0 = 6'h04;
  localparam logic [7:0] AddrHoleLo = 8'h14;
  localparam logic [7:0] AddrHoleHi = 8'h34;
  localparam logic [2:0] MaxLen = 3'd4;

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_e;

  // One lane's access for the cycle
  typedef struct packed {
    logic            rd_en;
    logic            we;
    logic [RowW-1:0] row;
    logic [7:0]      wdata;
  } bank_req_t;

  // Byte writes aimed at the BAR0 dword, indexed by byte within the dword
  typedef struct packed {
    logic [NumLanes-1:0] we;
    logic [31:0]         wdata;
  } bar_wr_t;

  // Reset contents of one configuration byte
  function automatic logic [7:0] reset_byte(input logic [7:0] addr);
    logic [7:0] val;
    unique case (addr)
      8'h00:                      val = 8'h34;
      8'h01:                      val = 8'h12;
      8'h02, 8'h03:               val = 8'h11;
      8'h04:                      val = 8'h03;
      8'h07:                      val = 8'h02;
      8'h0B:                      val = 8'h03;
      8'h10:                      val = BarReset[7:0];
      8'h11:                      val = BarReset[15:8];
      8'h12:                      val = BarReset[23:16];
      8'h13:                      val = BarReset[31:24];
      default:                    val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// File: src/cfgv_if.sv
// Valid/ready channel interfaces for configuration accesses and read results.
// Depends on nothing.
interface cfgv_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  address;
  logic [2:0]  access_length;
  logic [31:0] write_data;

  modport source (output valid, mode, address, access_length, write_data, input ready);
  modport sink (input valid, mode, address, access_length, write_data, output ready);
endinterface

interface cfgv_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// File: src/cfgv_bank.sv
// One byte lane of configuration storage: 64 x 8 synchronous memory, registered read.
// Entries never written read as their reset contents. Depends on cfgv_pkg.
module cfgv_bank (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          lane_i,
  input  cfgv_pkg::bank_req_t req_i,
  output logic [7:0]          rdata_o
);
  import cfgv_pkg::*;

  logic [7:0]        mem_q [RowCnt];
  logic [RowCnt-1:0] vld_q;
  logic [7:0]        rd_q;
  logic              rd_vld_q;
  logic [RowW-1:0]   rd_row_q;

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.row] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rd_q     <= mem_q[req_i.row];
      rd_vld_q <= vld_q[req_i.row];
      rd_row_q <= req_i.row;
    end
  end

  // Mark rows written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[req_i.row] <= 1'b1;
    end
  end

  // Fall back to reset contents for untouched rows
  assign rdata_o = rd_vld_q ? rd_q : reset_byte({rd_row_q, lane_i});

endmodule

// File: src/cfgv_bar.sv
// BAR0 dword register: byte merge, low-nibble keep and size-alignment mask.
// Depends on cfgv_pkg.
module cfgv_bar (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfgv_pkg::bar_wr_t wr_i,
  output logic [31:0]       bar_o
);
  import cfgv_pkg::*;

  logic [31:0] bar_q, bar_d;
  logic [31:0] merged;
  logic        changed;

  // Merge written bytes, keep byte 0 low nibble, mask on any change
  always_comb begin
    merged  = bar_q;
    changed = 1'b0;
    for (int b = 0; b < NumLanes; b++) begin
      if (wr_i.we[b]) begin
        merged[8*b +: 8] = wr_i.wdata[8*b +: 8];
      end
    end
    merged[3:0] = bar_q[3:0];
    changed = (merged != bar_q);
    bar_d = changed ? (merged & BarMask) : bar_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_q <= BarReset;
    end else begin
      bar_q <= bar_d;
    end
  end

  assign bar_o = bar_q;

  // Low nibble only ever holds the reset pattern or zero after a mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bar_q[3:0] == BarReset[3:0]) || (bar_q[3:0] == 4'h0))
    else $error("BAR0 low nibble corrupted");

  // Once masked, the dword stays aligned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bar_q & ~BarMask) == 32'h0 |=> (bar_q & ~BarMask) == 32'h0)
    else $error("BAR0 lost its alignment");

endmodule

// File: src/pci_config_space_vga.sv
// Top level of the display adapter PCI configuration space.
// Depends on cfgv_pkg, cfgv_if, cfgv_bank and cfgv_bar.
//
// Usage:
//   req_i carries one configuration access per beat: mode (0 read, 1 write),
//   byte address, access length and little-endian write data. rsp_o returns
//   one read_data beat for every read; writes return nothing.
//   Storage is four byte-lane memories of 64 rows, so the up to four bytes of
//   an access hit four different lanes and are read or written together.
//   The BAR0 dword lives in a register next to the memories.
//   Read path: a read accepted on req_i is registered in the lane memory read
//   stage, then in the output register, before it shows on rsp_o.
//   Throughput: one access per cycle, reads and writes alike, whenever
//   req_i.ready is high; it drops only in the stall case below.
//   Reset: the memories need no clearing pass; per-row valid bits make
//   untouched bytes read as their reset contents, so the block takes accesses
//   from the first cycle after reset.
//   Stall: while rsp_o is held, one more read waits in the memory output stage;
//   after that req_i.ready drops until the result is taken.
module pci_config_space_vga (
  input  logic  clk_i,
  input  logic  rst_ni,
  cfgv_req_if.sink   req_i,
  cfgv_rsp_if.source rsp_o
);
  import cfgv_pkg::*;

  bank_req_t        bank_req [NumLanes];
  logic [7:0]       bank_rdata [NumLanes];
  bar_wr_t          bar_wr;
  logic [31:0]      bar_q;

  logic             accept;
  logic             is_write;
  logic             wr_ok;
  logic             s1_adv;

  logic             s1_valid_q;
  logic [LaneW-1:0] s1_addr_lo_q;
  logic [NumLanes-1:0] s1_en_q;
  logic [NumLanes-1:0] s1_bar_q;
  logic             s1_bad_q;
  logic [31:0]      s1_bar_snap_q;
  logic [NumLanes-1:0] en_d;
  logic [NumLanes-1:0] bar_sel_d;
  logic [31:0]      s1_data;

  logic             out_valid_q;
  logic [31:0]      out_data_q;

  // Handshake
  assign s1_adv       = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready  = !s1_valid_q || s1_adv;
  assign accept       = req_i.valid && req_i.ready;
  assign is_write     = (req_i.mode == MODE_WRITE);
  assign wr_ok        = !((req_i.address >= AddrHoleLo) && (req_i.address < AddrHoleHi))
                        && (req_i.access_length <= MaxLen);

  // Steer each item byte to its lane
  always_comb begin
    logic [LaneW-1:0] k;
    logic [8:0]       a;
    logic             active;
    logic             is_bar;
    logic             prot;
    bar_wr    = '0;
    en_d      = '0;
    bar_sel_d = '0;
    for (int b = 0; b < NumLanes; b++) begin
      k      = LaneW'(b) - req_i.address[1:0];
      a      = {1'b0, req_i.address} + {7'd0, k};
      active = ({1'b0, k} < req_i.access_length) && !a[8];
      is_bar = (a[7:2] == RowBar0);
      prot   = (a[7:0] == AddrCmdLo) || (a[7:0] == AddrStsLo);
      bank_req[b].rd_en = accept && !is_write;
      bank_req[b].row   = a[7:2];
      bank_req[b].wdata = req_i.write_data[8*k +: 8];
      bank_req[b].we    = accept && is_write && wr_ok && active && !prot && !is_bar;
      bar_wr.we[b]              = accept && is_write && wr_ok && active && is_bar;
      bar_wr.wdata[8*b +: 8]    = req_i.write_data[8*k +: 8];
      en_d[b]      = active;
      bar_sel_d[b] = is_bar;
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    cfgv_bank u_bank (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .lane_i  (LaneW'(g)),
      .req_i   (bank_req[g]),
      .rdata_o (bank_rdata[g])
    );
  end

  cfgv_bar u_bar (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (bar_wr),
    .bar_o  (bar_q)
  );

  // Read stage: valid alongside the lane memory outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept && !is_write) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_write) begin
      s1_addr_lo_q  <= req_i.address[1:0];
      s1_en_q       <= en_d;
      s1_bar_q      <= bar_sel_d;
      s1_bad_q      <= (req_i.access_length == 3'd0) || (req_i.access_length > MaxLen);
      s1_bar_snap_q <= bar_q;
    end
  end

  // Rotate lanes back into item byte order
  always_comb begin
    logic [LaneW-1:0] b;
    s1_data = '0;
    for (int k = 0; k < NumLanes; k++) begin
      b = s1_addr_lo_q + LaneW'(k);
      if (s1_en_q[b]) begin
        s1_data[8*k +: 8] = s1_bar_q[b] ? s1_bar_snap_q[8*b +: 8] : bank_rdata[b];
      end
    end
    if (s1_bad_q) begin
      s1_data = '1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= s1_data;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;

  // A held read stays in the read stage until it moves on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("pending read dropped from read stage");

  // A new result only comes from the read stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result without a read");

  // Lane memories never take writes to protected or BAR0 bytes
  for (genvar g = 0; g < NumLanes; g++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      bank_req[g].we |-> !(bank_req[g].row == RowBar0) &&
        !({bank_req[g].row, LaneW'(g)} == AddrCmdLo) &&
        !({bank_req[g].row, LaneW'(g)} == AddrStsLo))
      else $error("write to a protected byte");
  end

  // Lane memory reads only start when a read is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_req[0].rd_en |-> req_i.ready && !bar_wr.we[0])
    else $error("memory read without accepted read");

endmodule

// File: tb/tb_pci_config_space_vga.sv
// Self-checking testbench for the display adapter PCI configuration space.
// Needs cfgv_pkg, the cfgv_req_if/cfgv_rsp_if interfaces and pci_config_space_vga.
`timescale 1ns / 1ps

module tb_pci_config_space_vga;
  import cfgv_pkg::*;

  localparam int unsigned RandAccesses = 523;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned PlanLen = 27;

  // Alignment mask that a changed BAR0 dword is cut down to
  localparam logic [63:0] ApertureBytes = 64'(VidMemMb) << 20;
  localparam logic [31:0] ApertureMask = 32'(~(ApertureBytes - 64'd1));
  localparam logic [7:0] AddrBar0 = 8'h10;
  localparam logic [7:0] AddrBar0Top = 8'h13;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  addr;
    logic [2:0]  len;
    logic [31:0] data;
    logic        fixed;
    logic [31:0] result;
  } access_row_t;

  // Directed accesses; typed results only where the value is obvious
  localparam access_row_t Plan [PlanLen] = '{
    '{MODE_READ,  8'h00, 3'd4, 32'h0,           1'b1, 32'h1111_1234},
    '{MODE_READ,  8'h04, 3'd4, 32'h0,           1'b1, 32'h0200_0003},
    '{MODE_READ,  8'h08, 3'd4, 32'h0,           1'b1, 32'h0300_0000},
    '{MODE_READ,  8'h10, 3'd4, 32'h0,           1'b1, FbBase | 32'h8},
    '{MODE_READ,  8'h00, 3'd0, 32'h0,           1'b1, AllOnes},
    '{MODE_READ,  8'h05, 3'd5, 32'h0,           1'b1, AllOnes},
    '{MODE_READ,  8'hFF, 3'd7, 32'hFFFF_FFFF,   1'b1, AllOnes},
    '{MODE_READ,  8'hFF, 3'd4, 32'h0,           1'b1, 32'h0},
    '{MODE_WRITE, 8'h04, 3'd4, 32'hFFFF_FFFF,   1'b0, 32'h0},
    '{MODE_READ,  8'h04, 3'd4, 32'h0,           1'b0, 32'h0},
    '{MODE_WRITE, 8'h10, 3'd4, 32'h1234_5678,   1'b0, 32'h0},
    '{MODE_READ,  8'h10, 3'd4, 32'h0,           1'b0, 32'h0},
    '{MODE_WRITE, 8'h14, 3'd4, 32'hFFFF_FFFF,   1'b0, 32'h0},
    '{MODE_WRITE, 8'h33, 3'd1, 32'hFFFF_FFFF,   1'b0, 32'h0},
    '{MODE_WRITE, 8'h12, 3'd4, 32'hAABB_CCDD,   1'b0, 32'h0},
    '{MODE_READ,  8'h12, 3'd4, 32'h0,           1'b0, 32'h0},
    '{MODE_WRITE, 8'h34, 3'd4, 32'hDEAD_BEEF,   1'b0, 32'h0},
    '{MODE_READ,  8'h34, 3'd4, 32'h0,           1'b0, 32'h0},
    '{MODE_WRITE, 8'hFE, 3'd4, 32'h0102_0304,   1'b0, 32'h0},
    '{MODE_READ,  8'hFD, 3'd4, 32'h0,           1'b0, 32'h0},
    '{MODE_WRITE, 8'h40, 3'd5, 32'h5555_5555,   1'b0, 32'h0},
    '{MODE_WRITE, 8'h40, 3'd0, 32'hAAAA_AAAA,   1'b0, 32'h0},
    '{MODE_READ,  8'h40, 3'd4, 32'h0,           1'b0, 32'h0},
    '{MODE_WRITE, 8'h10, 3'd1, 32'h0000_000F,   1'b0, 32'h0},
    '{MODE_WRITE, 8'h10, 3'd1, 32'h0000_00F5,   1'b0, 32'h0},
    '{MODE_READ,  8'h10, 3'd3, 32'h0,           1'b0, 32'h0},
    '{MODE_WRITE, 8'h00, 3'd4, 32'hFFFF_FFFF,   1'b0, 32'h0}
  };

  logic clk_i;
  logic rst_ni;
  logic calm;

  cfgv_req_if req_if ();
  cfgv_rsp_if rsp_if ();

  pci_config_space_vga dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Shadow of the 256 configuration bytes and the reads still owed
  logic [7:0]  space_bytes [256];
  logic [31:0] pending_reads [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  int unsigned calm_timer;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Load the power-on contents
  function automatic void space_reset();
    logic [31:0] bar;
    bar = FbBase | 32'h0000_0008;
    foreach (space_bytes[i]) space_bytes[i] = 8'h00;
    space_bytes[8'h00] = 8'h34;
    space_bytes[8'h01] = 8'h12;
    space_bytes[8'h02] = 8'h11;
    space_bytes[8'h03] = 8'h11;
    space_bytes[AddrCmdLo] = 8'h03;
    space_bytes[8'h07] = 8'h02;
    space_bytes[8'h0B] = 8'h03;
    for (int k = 0; k < 4; k++) space_bytes[AddrBar0 + k] = bar[8*k +: 8];
  endfunction

  // Little-endian read; bytes past the top read as zero, bad lengths as all ones
  function automatic logic [31:0] space_read(input logic [7:0] addr, input logic [2:0] len);
    logic [31:0] val;
    int unsigned a;
    val = '0;
    if (len == 3'd0 || len > MaxLen) return AllOnes;
    for (int k = 0; k < int'(len); k++) begin
      a = int'(addr) + k;
      if (a <= 255) val[8*k +: 8] = space_bytes[a];
    end
    return val;
  endfunction

  // Store a write, honoring protected bytes, the hole and the BAR0 rules
  function automatic void space_write(input logic [7:0] addr, input logic [2:0] len,
                                      input logic [31:0] data);
    logic [7:0]  nv;
    logic [7:0]  ov;
    logic [31:0] bar;
    logic        bar_moved;
    int unsigned a;
    bar_moved = 1'b0;
    if (addr >= AddrHoleLo && addr < AddrHoleHi) return;
    if (len > MaxLen) return;
    for (int k = 0; k < int'(len); k++) begin
      a = int'(addr) + k;
      if (a <= 255) begin
        nv = data[8*k +: 8];
        ov = space_bytes[a];
        if (a == AddrCmdLo || a == AddrStsLo) begin
          nv = ov;
        end else if (a >= AddrBar0 && a <= AddrBar0Top) begin
          if (a == AddrBar0) nv = {nv[7:4], ov[3:0]};
          if (nv != ov) bar_moved = 1'b1;
        end
        space_bytes[a] = nv;
      end
    end
    if (bar_moved) begin
      for (int k = 0; k < 4; k++) bar[8*k +: 8] = space_bytes[AddrBar0 + k];
      bar = bar & ApertureMask;
      for (int k = 0; k < 4; k++) space_bytes[AddrBar0 + k] = bar[8*k +: 8];
    end
  endfunction

  // Sender gap: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one access beat and update the shadow when it is taken
  task automatic send_access(input mode_e mode, input logic [7:0] addr, input logic [2:0] len,
                             input logic [31:0] data, input logic fixed,
                             input logic [31:0] result);
    int unsigned gap;
    logic [31:0] val;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.mode          <= mode;
    req_if.address       <= addr;
    req_if.access_length <= len;
    req_if.write_data    <= data;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (mode == MODE_READ) begin
      val = space_read(addr, len);
      pending_reads.push_back(fixed ? result : val);
    end else begin
      space_write(addr, len, data);
    end
  endtask

  // Random address, biased toward the header, BAR0, the hole and the top
  function automatic logic [7:0] pick_addr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 8'($urandom_range(0, 19));
    if (r < 40) return 8'($urandom_range(12, 19));
    if (r < 50) return 8'($urandom_range(20, 51));
    if (r < 60) return 8'($urandom_range(252, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return AllOnes;
    if (r < 10) return 32'h0;
    if (r < 15) return {4{8'($urandom_range(0, 255))}};
    return $urandom;
  endfunction

  // Response side: random stalls, with calm stretches that start no new stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
      calm         <= 1'b0;
      calm_timer   <= 0;
    end else begin
      calm_timer <= calm_timer + 1;
      if (calm_timer % 128 == 127) calm <= ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        rsp_if.ready <= 1'b0;
        stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                    : $urandom_range(0, 2);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Check each read beat against the oldest owed value
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_reads.size() == 0) begin
        $error("read_data beat with no read outstanding: actual %h", rsp_if.read_data);
        mismatches++;
      end else begin
        if (rsp_if.read_data !== pending_reads[0]) begin
          $error("read_data mismatch: expected %h, actual %h", pending_reads[0],
                 rsp_if.read_data);
          mismatches++;
        end
        void'(pending_reads.pop_front());
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    mode_e       mode;
    logic [7:0]  addr;
    logic [2:0]  len;
    logic [31:0] data;
    int unsigned counted;
    bit          pressed;
    mismatches           = 0;
    quiet_cycles         = 0;
    counted              = 0;
    pressed              = 1'b0;
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.mode          = MODE_READ;
    req_if.address       = '0;
    req_if.access_length = '0;
    req_if.write_data    = '0;
    space_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    foreach (Plan[i]) begin
      send_access(Plan[i].mode, Plan[i].addr, Plan[i].len, Plan[i].data, Plan[i].fixed,
                  Plan[i].result);
    end

    // Random part
    while (counted < RandAccesses) begin
      mode = ($urandom_range(0, 1) == 1) ? MODE_WRITE : MODE_READ;
      addr = pick_addr();
      len  = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
      data = pick_data();
      send_access(mode, addr, len, data, 1'b0, 32'h0);
      counted++;
      // Hold off once until every owed read has come back
      if (!pressed && counted == RandAccesses / 2) begin
        pressed = 1'b1;
        req_if.valid <= 1'b0;
        do @(posedge clk_i); while (pending_reads.size() != 0);
      end
    end
    req_if.valid <= 1'b0;

    // Drain the response side
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/cfgv_pkg.sv
src/cfgv_if.sv
src/cfgv_bank.sv
src/cfgv_bar.sv
src/pci_config_space_vga.sv
tb/tb_pci_config_space_vga.sv
